/* rtl/vsa_pkg.sv */
`default_nettype none

package vsa_pkg;

    localparam int NUM_SLOTS_DEF = 32;
    localparam int SER_W         = 32;
    localparam int SLOT_OUT_W    = 5;
    localparam int CNT_OUT_W     = 6;

    localparam logic [1:0] PH_FREE     = 2'd0;
    localparam logic [1:0] PH_ACTIVE   = 2'd1;
    localparam logic [1:0] PH_FINISHED = 2'd2;

    localparam logic [1:0] MODE_CLAIM   = 2'd0;
    localparam logic [1:0] MODE_FINISH  = 2'd1;
    localparam logic [1:0] MODE_REL_SER = 2'd2;
    localparam logic [1:0] MODE_REL_ALL = 2'd3;

    typedef struct packed {
        logic [1:0]       phase;
        logic [SER_W-1:0] serial;
        logic             rel;
    } t_slot;

    typedef struct packed {
        logic                  granted;
        logic [SLOT_OUT_W-1:0] gslot;
        logic [SER_W-1:0]      gserial;
        logic                  stole;
        logic [SLOT_OUT_W-1:0] sslot;
        logic                  found;
        logic [CNT_OUT_W-1:0]  count;
    } t_result;

endpackage

`default_nettype wire

/* rtl/vsa_cell.sv */
`default_nettype none

module vsa_cell
    import vsa_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_shift,
    input  wire   i_set_rel,
    input  t_slot i_din,
    output t_slot o_dout
);

    t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.phase <= PH_FREE;
            r_slot.rel   <= 1'b0;
        end else if (i_shift) begin
            r_slot.phase <= i_din.phase;
            r_slot.rel   <= i_din.rel;
        end else if (i_set_rel) begin
            r_slot.rel   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_slot.serial <= i_din.serial;
        end
    end

    assign o_dout = r_slot;

endmodule

`default_nettype wire

/* rtl/vsa_head.sv */
`default_nettype none

module vsa_head
    import vsa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    localparam int SW = $clog2(NUM_SLOTS),
    localparam int CW = (SW > SLOT_OUT_W) ? SW : SLOT_OUT_W
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire                   i_step,
    input  wire [1:0]             i_mode,
    input  wire [SLOT_OUT_W-1:0]  i_slot_index,
    input  wire [SER_W-1:0]       i_voice_serial,
    input  wire [SW-1:0]          i_pos,
    input  t_slot                 i_cur,
    output t_slot                 o_next,
    output logic [SW-1:0]         o_best,
    output t_result               o_res
);

    logic [1:0]            r_mode;
    logic [SLOT_OUT_W-1:0] r_idx;
    logic [SER_W-1:0]      r_ser;
    logic                  r_got, n_got;
    logic [SW-1:0]         r_gslot, n_gslot;
    logic [SER_W-1:0]      r_gser, n_gser;
    logic                  r_have, n_have;
    logic [SW-1:0]         r_best, n_best;
    logic [SER_W-1:0]      r_best_ser, n_best_ser;
    logic                  r_found, n_found;
    logic [CNT_OUT_W-1:0]  r_count, n_count;
    logic [SER_W-1:0]      r_ctr, n_ctr;
    logic [SER_W-1:0]      w_new_ser;
    logic                  w_in_use;
    t_slot                 w_next;

    always_comb begin
        w_next     = i_cur;
        n_got      = r_got;
        n_gslot    = r_gslot;
        n_gser     = r_gser;
        n_have     = r_have;
        n_best     = r_best;
        n_best_ser = r_best_ser;
        n_found    = r_found;
        n_ctr      = r_ctr;
        w_new_ser  = r_ctr + 1'b1;
        if (w_new_ser == '0) begin
            w_new_ser = {{(SER_W-1){1'b0}}, 1'b1};
        end
        w_in_use = (i_cur.phase == PH_ACTIVE) || (i_cur.phase == PH_FINISHED);

        unique case (r_mode)
            MODE_CLAIM: begin
                if (i_cur.phase == PH_FINISHED) begin
                    w_next.phase  = PH_FREE;
                    w_next.serial = '0;
                    w_next.rel    = 1'b0;
                end
                if (((i_cur.phase == PH_FREE) || (i_cur.phase == PH_FINISHED)) && !r_got) begin
                    w_next.phase  = PH_ACTIVE;
                    w_next.serial = w_new_ser;
                    w_next.rel    = 1'b0;
                    n_got         = 1'b1;
                    n_gslot       = i_pos;
                    n_gser        = w_new_ser;
                    n_ctr         = w_new_ser;
                end
                if ((i_cur.phase == PH_ACTIVE) && (!r_have || (i_cur.serial < r_best_ser))) begin
                    n_have     = 1'b1;
                    n_best     = i_pos;
                    n_best_ser = i_cur.serial;
                end
            end
            MODE_FINISH: begin
                if ((CW'(i_pos) == CW'(r_idx)) && (i_cur.phase == PH_ACTIVE)) begin
                    w_next.phase = PH_FINISHED;
                end
            end
            MODE_REL_SER: begin
                if ((r_ser != '0) && w_in_use && (i_cur.serial == r_ser) && !r_found) begin
                    w_next.rel = 1'b1;
                    n_found    = 1'b1;
                end
            end
            MODE_REL_ALL: begin
                if (w_in_use) begin
                    w_next.rel = 1'b1;
                end
            end
            default: ;
        endcase

        n_count = r_count + CNT_OUT_W'(w_next.phase == PH_ACTIVE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_got   <= 1'b0;
            r_have  <= 1'b0;
            r_found <= 1'b0;
            r_ctr   <= '0;
        end else if (i_start) begin
            r_got   <= 1'b0;
            r_have  <= 1'b0;
            r_found <= 1'b0;
        end else if (i_step) begin
            r_got   <= n_got;
            r_have  <= n_have;
            r_found <= n_found;
            r_ctr   <= n_ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mode     <= i_mode;
            r_idx      <= i_slot_index;
            r_ser      <= i_voice_serial;
            r_gslot    <= '0;
            r_gser     <= '0;
            r_best     <= '0;
            r_best_ser <= '0;
            r_count    <= '0;
        end else if (i_step) begin
            r_gslot    <= n_gslot;
            r_gser     <= n_gser;
            r_best     <= n_best;
            r_best_ser <= n_best_ser;
            r_count    <= n_count;
        end
    end

    assign o_next = w_next;
    assign o_best = r_best;

    always_comb begin
        o_res.granted = r_got;
        o_res.gslot   = SLOT_OUT_W'(r_gslot);
        o_res.gserial = r_gser;
        o_res.stole   = (r_mode == MODE_CLAIM) && !r_got && r_have;
        o_res.sslot   = o_res.stole ? SLOT_OUT_W'(r_best) : '0;
        o_res.found   = r_found;
        o_res.count   = r_count;
    end

endmodule

`default_nettype wire

/* rtl/voice_slot_allocator.sv */
`default_nettype none

// Voice slot allocator. The slots sit in a ring of cells that, while a request is being
// scanned, rotates one slot per cycle past a single update unit, so every request visits
// each slot once in index order: claims reclaim finished slots and grant the lowest free
// one, finish, release-by-serial and release-all update the slot as it passes. After the
// scan the result is loaded into the output register from the finish state, and the next
// request can be taken once the allocator is back in idle; a refused claim flags its
// steal target while the result waits in the finish state. o_stall stays high while a
// request is in the ring; a finished result waits in the output register while the next
// request is accepted, and a scan that ends while that result is still held waits until
// the output register is free.
module voice_slot_allocator
    import vsa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire [1:0]              i_mode,
    input  wire [SLOT_OUT_W-1:0]   i_slot_index,
    input  wire [SER_W-1:0]        i_voice_serial,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic                   o_granted,
    output logic [SLOT_OUT_W-1:0]  o_granted_slot,
    output logic [SER_W-1:0]       o_granted_serial,
    output logic                   o_stole,
    output logic [SLOT_OUT_W-1:0]  o_stolen_slot,
    output logic                   o_found,
    output logic [CNT_OUT_W-1:0]   o_active_count
);

    localparam int SW = $clog2(NUM_SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [SW-1:0] r_pos;
    logic          r_ovalid;
    t_result       r_res;
    t_result       w_res;
    t_slot         w_cell [NUM_SLOTS];
    t_slot         w_next;
    logic [SW-1:0] w_best;
    logic          w_accept;
    logic          w_shift;
    logic          w_last;
    logic          w_load;

    assign w_accept = i_valid && !o_stall;
    assign w_shift  = (r_state == S_SCAN);
    assign w_last   = (r_pos == SW'(NUM_SLOTS - 1));
    assign w_load   = (r_state == S_FIN) && (!r_ovalid || !i_stall);

    vsa_head #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_head (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_accept),
        .i_step         (w_shift),
        .i_mode         (i_mode),
        .i_slot_index   (i_slot_index),
        .i_voice_serial (i_voice_serial),
        .i_pos          (r_pos),
        .i_cur          (w_cell[0]),
        .o_next         (w_next),
        .o_best         (w_best),
        .o_res          (w_res)
    );

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        t_slot w_din;
        logic  w_set;

        if (k == NUM_SLOTS - 1) begin : g_tail
            assign w_din = w_next;
        end else begin : g_body
            assign w_din = w_cell[k+1];
        end

        assign w_set = (r_state == S_FIN) && w_res.stole && (w_best == SW'(k));

        vsa_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (w_shift),
            .i_set_rel (w_set),
            .i_din     (w_din),
            .o_dout    (w_cell[k])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_pos <= '0;
            end else if (w_shift) begin
                r_pos <= r_pos + 1'b1;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= w_res;
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_granted        = r_res.granted;
    assign o_granted_slot   = r_res.gslot;
    assign o_granted_serial = r_res.gserial;
    assign o_stole          = r_res.stole;
    assign o_stolen_slot    = r_res.sslot;
    assign o_found          = r_res.found;
    assign o_active_count   = r_res.count;

    // a claim either grants or steals, never both
    a_grant_xor_steal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_granted && o_stole))
        else $error("grant and steal in one result");

    // granted serials skip zero
    a_serial_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_granted) |-> (o_granted_serial != '0))
        else $error("granted serial is zero");

    // a release match never comes with a grant or steal
    a_found_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (!o_granted && !o_stole))
        else $error("found flag mixed with claim result");

    // the ring is busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall && (r_pos == '0)))
        else $error("request taken without starting a scan");

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import vsa_pkg::*;

    localparam int SLOTS        = NUM_SLOTS_DEF;
    localparam int IDLE_PCT     = 23;
    localparam int RAND_ITEMS   = 1300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * (NUM_SLOTS_DEF + 2);
    localparam int LIMIT_CYCLES = 400000;
    localparam int DIR_ROWS     = 22;

    typedef struct {
        logic [1:0]  mode;
        logic [4:0]  idx;
        logic [31:0] ser;
        bit          typed;
        t_result     want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_mode;
    logic [SLOT_OUT_W-1:0] i_slot_index;
    logic [SER_W-1:0]      i_voice_serial;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_granted;
    logic [SLOT_OUT_W-1:0] o_granted_slot;
    logic [SER_W-1:0]      o_granted_serial;
    logic                  o_stole;
    logic [SLOT_OUT_W-1:0] o_stolen_slot;
    logic                  o_found;
    logic [CNT_OUT_W-1:0]  o_active_count;

    logic [1:0]       ph     [SLOTS];
    logic [SER_W-1:0] ser_of [SLOTS];
    logic             rel_of [SLOTS];
    logic [SER_W-1:0] serial_ctr;

    t_result  replies_due [$];
    t_dir_row dir_rows [DIR_ROWS];
    int       mismatches = 0;
    int       cycles = 0;
    bit       calm = 1'b0;
    bit       hold_req = 1'b0;
    int       hold_left = 0;

    voice_slot_allocator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_slot_index     (i_slot_index),
        .i_voice_serial   (i_voice_serial),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_granted        (o_granted),
        .o_granted_slot   (o_granted_slot),
        .o_granted_serial (o_granted_serial),
        .o_stole          (o_stole),
        .o_stolen_slot    (o_stolen_slot),
        .o_found          (o_found),
        .o_active_count   (o_active_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    initial begin
        wait (cycles >= LIMIT_CYCLES);
        $display("testbench: errors");
        $finish;
    end

    function automatic t_dir_row row(input logic [1:0] m, input logic [4:0] x,
                                     input logic [31:0] s, input bit t, input logic g,
                                     input logic [4:0] gs, input logic [31:0] gv,
                                     input logic f, input logic [5:0] c);
        t_dir_row r;
        r.mode  = m;
        r.idx   = x;
        r.ser   = s;
        r.typed = t;
        r.want  = '{g, gs, gv, 1'b0, 5'd0, f, c};
        return r;
    endfunction

    function automatic t_result allocate_step(input logic [1:0] m, input logic [4:0] x,
                                              input logic [31:0] s);
        t_result res;
        int      i;
        int      pick;
        int      oldest;
        int      act;
        res    = '0;
        pick   = -1;
        oldest = -1;
        act    = 0;
        case (m)
            MODE_CLAIM: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (ph[i] == PH_FINISHED) begin
                        ph[i]     = PH_FREE;
                        ser_of[i] = '0;
                        rel_of[i] = 1'b0;
                    end
                end
                for (i = SLOTS - 1; i >= 0; i--) begin
                    if (ph[i] == PH_FREE) pick = i;
                end
                if (pick >= 0) begin
                    serial_ctr = serial_ctr + 1;
                    if (serial_ctr == '0) serial_ctr = 1;
                    ph[pick]     = PH_ACTIVE;
                    ser_of[pick] = serial_ctr;
                    rel_of[pick] = 1'b0;
                    res.granted  = 1'b1;
                    res.gslot    = SLOT_OUT_W'(pick);
                    res.gserial  = serial_ctr;
                end else begin
                    for (i = 0; i < SLOTS; i++) begin
                        if (ph[i] == PH_ACTIVE && (oldest < 0 || ser_of[i] < ser_of[oldest]))
                            oldest = i;
                    end
                    if (oldest >= 0) begin
                        rel_of[oldest] = 1'b1;
                        res.stole      = 1'b1;
                        res.sslot      = SLOT_OUT_W'(oldest);
                    end
                end
            end
            MODE_FINISH: begin
                if (int'(x) < SLOTS && ph[x] == PH_ACTIVE) ph[x] = PH_FINISHED;
            end
            MODE_REL_SER: begin
                if (s != '0) begin
                    for (i = 0; i < SLOTS; i++) begin
                        if (!res.found && (ph[i] == PH_ACTIVE || ph[i] == PH_FINISHED)
                            && ser_of[i] == s) begin
                            rel_of[i] = 1'b1;
                            res.found = 1'b1;
                        end
                    end
                end
            end
            MODE_REL_ALL: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (ph[i] == PH_ACTIVE || ph[i] == PH_FINISHED) rel_of[i] = 1'b1;
                end
            end
        endcase
        for (i = 0; i < SLOTS; i++) begin
            if (ph[i] == PH_ACTIVE) act++;
        end
        res.count = CNT_OUT_W'(act);
        return res;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue(input logic [1:0] m, input logic [4:0] x, input logic [31:0] s,
                         input bit typed, input t_result want);
        t_result model_res;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= m;
        i_slot_index   <= x;
        i_voice_serial <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        model_res = allocate_step(m, x, s);
        replies_due.push_back(typed ? want : model_res);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (replies_due.size() == 0) begin
                $display("%0t: result with no request pending", $time);
                mismatches++;
            end else begin
                due = replies_due.pop_front();
                check_field("granted", 32'(due.granted), 32'(o_granted));
                check_field("granted_slot", 32'(due.gslot), 32'(o_granted_slot));
                check_field("granted_serial", due.gserial, o_granted_serial);
                check_field("stole", 32'(due.stole), 32'(o_stole));
                check_field("stolen_slot", 32'(due.sslot), 32'(o_stolen_slot));
                check_field("found", 32'(due.found), 32'(o_found));
                check_field("active_count", 32'(due.count), 32'(o_active_count));
            end
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        int          n;
        int          k;
        int          r;
        int          claim_pct;
        logic [1:0]  m;
        logic [4:0]  x;
        logic [31:0] s;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_mode         = MODE_CLAIM;
        i_slot_index   = '0;
        i_voice_serial = '0;
        for (k = 0; k < SLOTS; k++) begin
            ph[k]     = PH_FREE;
            ser_of[k] = '0;
            rel_of[k] = 1'b0;
        end
        serial_ctr = '0;
        claim_pct  = 70;

        dir_rows[0]  = row(MODE_REL_ALL, 0, 0, 1, 0, 0, 0, 0, 0);
        dir_rows[1]  = row(MODE_REL_SER, 0, 0, 1, 0, 0, 0, 0, 0);
        dir_rows[2]  = row(MODE_FINISH, 31, 0, 1, 0, 0, 0, 0, 0);
        dir_rows[3]  = row(MODE_CLAIM, 0, 0, 1, 1, 0, 1, 0, 1);
        dir_rows[4]  = row(MODE_CLAIM, 31, 32'hFFFF_FFFF, 1, 1, 1, 2, 0, 2);
        dir_rows[5]  = row(MODE_REL_SER, 31, 1, 1, 0, 0, 0, 1, 2);
        dir_rows[6]  = row(MODE_REL_SER, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 2);
        dir_rows[7]  = row(MODE_REL_SER, 31, 0, 1, 0, 0, 0, 0, 2);
        dir_rows[8]  = row(MODE_FINISH, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 1);
        dir_rows[9]  = row(MODE_FINISH, 0, 0, 1, 0, 0, 0, 0, 1);
        dir_rows[10] = row(MODE_REL_SER, 0, 1, 1, 0, 0, 0, 1, 1);
        dir_rows[11] = row(MODE_REL_ALL, 31, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 1);
        dir_rows[12] = row(MODE_CLAIM, 0, 0, 1, 1, 0, 3, 0, 2);
        dir_rows[13] = row(MODE_FINISH, 1, 0, 1, 0, 0, 0, 0, 1);
        dir_rows[14] = row(MODE_FINISH, 31, 0, 1, 0, 0, 0, 0, 1);
        dir_rows[15] = row(MODE_CLAIM, 0, 0, 1, 1, 1, 4, 0, 2);
        dir_rows[16] = row(MODE_CLAIM, 0, 0, 1, 1, 2, 5, 0, 3);
        dir_rows[17] = row(MODE_REL_SER, 0, 2, 1, 0, 0, 0, 0, 3);
        dir_rows[18] = row(MODE_REL_SER, 31, 5, 0, 0, 0, 0, 0, 0);
        dir_rows[19] = row(MODE_FINISH, 2, 0, 0, 0, 0, 0, 0, 0);
        dir_rows[20] = row(MODE_CLAIM, 31, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        dir_rows[21] = row(MODE_REL_ALL, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < DIR_ROWS; n++)
            issue(dir_rows[n].mode, dir_rows[n].idx, dir_rows[n].ser, dir_rows[n].typed,
                  dir_rows[n].want);

        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 100 == 0 && n > 0) begin
                r = $urandom_range(2);
                claim_pct = (r == 0) ? 25 : (r == 1) ? 45 : 70;
            end
            calm = (n >= 600 && n < 900);
            if (n == 300) hold_req = 1'b1;
            x = $urandom_range(31);
            s = $urandom;
            r = $urandom_range(99);
            if (r < claim_pct) begin
                m = MODE_CLAIM;
            end else if (r < claim_pct + 30) begin
                m = MODE_FINISH;
                if ($urandom_range(99) < 80) begin
                    for (k = 0; k < SLOTS && ph[x] != PH_ACTIVE; k++)
                        x = 5'(int'(x) + 1);
                end
            end else if (r < 97) begin
                m = MODE_REL_SER;
                r = $urandom_range(99);
                if (r < 55) s = ser_of[$urandom_range(SLOTS - 1)];
                else if (r < 70) s = '0;
                else if (r < 90) s = serial_ctr - 32'($urandom_range(40));
            end else begin
                m = MODE_REL_ALL;
            end
            issue(m, x, s, 1'b0, '0);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        wait (replies_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

/* voice_slot_allocator.f */
rtl/vsa_pkg.sv
rtl/vsa_cell.sv
rtl/vsa_head.sv
rtl/voice_slot_allocator.sv
verif/testbench.sv
